>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/irgavg_pkg.sv
// ----------------------------------------------------------------------------
// irgavg_pkg
// Constants, register codes and the distance table function for the
// infrared range converter with gated average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irgavg_pkg;

    localparam int WINDOW   = 5;
    localparam int ADC_BITS = 10;

    localparam int DIST_W    = 14;
    localparam int AVG_W     = 8;
    localparam int CNT_OUT_W = 3;
    localparam int CFG_W     = 8;
    localparam int CFG_AW    = 1;
    localparam int CMD_W     = 1;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - DIST_W - AVG_W - CNT_OUT_W;

    localparam int ROM_DEPTH = 2 ** ADC_BITS;
    localparam int HIST_AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = $clog2(WINDOW * 255 + 1);
    localparam int STEP_W    = $clog2(SUM_W);

    localparam logic [DIST_W-1:0] CLEAR_VALUE = 14'd39;
    localparam int                DIST_MAX    = 10640;
    localparam logic [CFG_W-1:0]  VALID_LIMIT_RST = 8'd30;
    localparam logic [CFG_W-1:0]  FALLBACK_RST    = 8'd40;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_VALID_LIMIT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_FALLBACK    = 1'b1;

    // command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 1'b1;

    // log2 in unsigned q32: integer part from bit 32 up, fraction by repeated squaring
    function automatic logic [63:0] log2_q32(input logic [31:0] v);
        logic [5:0]  n;
        logic [63:0] m;
        logic [31:0] frac;
        n    = '0;
        frac = '0;
        if (v == 32'd0) begin
            return 64'd0;
        end
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(i);
            end
        end
        m = {32'd0, v} << (6'd31 - n);
        for (int k = 0; k < 32; k++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h0000_0001_0000_0000) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {26'd0, n, frac};
    endfunction

    // rounded distance for one raw reading, evaluated while building the table
    function automatic logic [DIST_W-1:0] dist_of(input int unsigned x);
        longint      c;
        longint      t;
        longint      lim;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned d;
        lo = 0;
        hi = 16383;
        if (x == 0) begin
            return DIST_W'(DIST_MAX);
        end
        c   = longint'(log2_q32(32'd1065008)) - longint'(log2_q32(32'd100));
        t   = c - longint'((log2_q32(32'(x)) * 64'd935) / 64'd1000);
        lim = t + longint'(64'h0000_0001_0000_0000);
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (longint'(log2_q32(32'(2 * mid - 1))) <= lim) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (lo < 10) begin
            return '0;
        end
        d = lo - 10;
        if (d > DIST_MAX) begin
            return DIST_W'(DIST_MAX);
        end
        return DIST_W'(d);
    endfunction

endpackage

`default_nettype wire

>>> sv/irgavg_ram.sv
// ----------------------------------------------------------------------------
// irgavg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irgavg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/irgavg_rom.sv
// ----------------------------------------------------------------------------
// irgavg_rom
// Reading-to-centimetre table, one entry per raw reading, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irgavg_rom
    import irgavg_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic [ADC_BITS-1:0] rd_addr,
    output logic      [DIST_W-1:0]   rd_data
);

    logic [DIST_W-1:0] rom_arr [ROM_DEPTH];
    logic [DIST_W-1:0] rd_data_reg;

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_entry
        localparam logic [DIST_W-1:0] ENTRY = dist_of(g);
        assign rom_arr[g] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rom_arr[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/irgavg_div.sv
// ----------------------------------------------------------------------------
// irgavg_div
// Restoring divider, one quotient bit per cycle, for sum over valid count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irgavg_div
    import irgavg_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic      [SUM_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;

    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] diff;
    logic           ge;

    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            rem_next  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/ir_range_to_cm_with_gated_average_core.sv
// ----------------------------------------------------------------------------
// ir_range_to_cm_with_gated_average_core
// Converts a raw range reading to centimetres and reports a gated average
// over a short history held in a small RAM.
// ----------------------------------------------------------------------------
//  channel   ports            payload
//  input     s_axis_*         tuser: command; tdata: adc_sample
//  result    m_axis_*         tdata: distance_cm, averaged_cm, valid_count
//  config    cfg_*            0: valid_limit, 1: fallback_value
//
//  a sample passes through one table read, one history RAM read per entry,
//  then a bit-serial divide. a clear gives no result.
//  aresetn is synchronous; history reads 39 until written, no clearing pass.
//  a finished result waits in the output register while the next request is
//  taken; the block stalls only if a second result is ready before then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_range_to_cm_with_gated_average_core
    import irgavg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [9:0] adc_sample
    input  wire logic [CMD_W-1:0]     s_axis_tuser,  // [0] command
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [13:0] distance_cm, [21:14] averaged_cm, [24:22] valid_count
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ROM  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       valid_limit_reg, valid_limit_next;
    logic [CFG_W-1:0]       fallback_reg, fallback_next;
    logic [WINDOW-1:0]      hist_vld_reg, hist_vld_next;
    logic [HIST_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   m_valid_reg, m_valid_next;

    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ent_vld_reg, ent_vld_next;
    logic [AVG_W-1:0]       avg_reg, avg_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                   in_fire;
    logic [DIST_W-1:0]      rom_data;
    logic                   ram_wr_en;
    logic [HIST_AW-1:0]     ram_rd_addr;
    logic [DIST_W-1:0]      ram_rd_data;
    logic [DIST_W-1:0]      entry;
    logic                   entry_pass;
    logic [SUM_W-1:0]       sum_acc;
    logic [CNT_W-1:0]       cnt_acc;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quotient;
    logic                   avg_ok;
    logic                   out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    irgavg_rom u_rom (
        .aclk    (aclk),
        .rd_addr (s_axis_tdata[ADC_BITS-1:0]),
        .rd_data (rom_data)
    );

    irgavg_ram #(
        .DATA_W (DIST_W),
        .DEPTH  (WINDOW)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (rom_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    irgavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_acc),
        .divisor  (cnt_acc),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign ram_wr_en   = (state_reg == ST_ROM);
    assign ram_rd_addr = (idx_reg < CNT_W'(WINDOW)) ? idx_reg[HIST_AW-1:0] : '0;

    // an entry never written since reset or clear reads as the clear value
    assign entry      = ent_vld_reg ? ram_rd_data : CLEAR_VALUE;
    assign entry_pass = (entry != '0) && (entry < DIST_W'(valid_limit_reg));
    assign sum_acc    = sum_reg + (entry_pass ? SUM_W'(entry) : '0);
    assign cnt_acc    = cnt_reg + (entry_pass ? CNT_W'(1) : '0);

    assign avg_ok = (cnt_reg != '0) && (div_quotient != '0)
                    && (div_quotient < SUM_W'(fallback_reg));

    always_comb begin
        state_next       = state_reg;
        valid_limit_next = valid_limit_reg;
        fallback_next    = fallback_reg;
        hist_vld_next    = hist_vld_reg;
        wr_ptr_next      = wr_ptr_reg;
        idx_next         = idx_reg;
        m_valid_next     = m_valid_reg;
        dist_next        = dist_reg;
        sum_next         = sum_reg;
        cnt_next         = cnt_reg;
        ent_vld_next     = ent_vld_reg;
        avg_next         = avg_reg;
        m_data_next      = m_data_reg;
        div_start        = 1'b0;

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_VALID_LIMIT: valid_limit_next = cfg_wdata;
                REG_FALLBACK:    fallback_next    = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tuser)
                        CMD_CLEAR:  hist_vld_next = '0;
                        CMD_SAMPLE: state_next    = ST_ROM;
                        default: ;
                    endcase
                end
            end
            ST_ROM: begin
                // table data is here; write it into the history slot
                dist_next                 = rom_data;
                hist_vld_next[wr_ptr_reg] = 1'b1;
                wr_ptr_next = (wr_ptr_reg == HIST_AW'(WINDOW - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
                idx_next   = '0;
                sum_next   = '0;
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // read entry idx while accumulating entry idx-1
                if (idx_reg < CNT_W'(WINDOW)) begin
                    ent_vld_next = hist_vld_reg[idx_reg[HIST_AW-1:0]];
                end
                if (idx_reg != '0) begin
                    sum_next = sum_acc;
                    cnt_next = cnt_acc;
                end
                if (idx_reg == CNT_W'(WINDOW)) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next   = avg_ok ? AVG_W'(div_quotient) : fallback_reg;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_next  = {M_PAD_W'(0), CNT_OUT_W'(cnt_reg), avg_reg, dist_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            valid_limit_reg <= VALID_LIMIT_RST;
            fallback_reg    <= FALLBACK_RST;
            hist_vld_reg    <= '0;
            wr_ptr_reg      <= '0;
            idx_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            valid_limit_reg <= valid_limit_next;
            fallback_reg    <= fallback_next;
            hist_vld_reg    <= hist_vld_next;
            wr_ptr_reg      <= wr_ptr_next;
            idx_reg         <= idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg    <= dist_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        ent_vld_reg <= ent_vld_next;
        avg_reg     <= avg_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> sv/irgavg_checker.sv
// ----------------------------------------------------------------------------
// irgavg_checker
// Port-level checks for the range converter core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module irgavg_checker
    import irgavg_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [CMD_W-1:0]     s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_LO = DIST_W + AVG_W;
    localparam int PAD_LO = CNT_LO + CNT_OUT_W;

    // a stalled result keeps its payload
    `ASSERT_RST(a_out_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "result changed while stalled")

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_axis_tvalid,
        "result valid right after reset")

    `ASSERT_RST(a_count_range, aclk, aresetn,
        m_axis_tvalid |-> m_axis_tdata[PAD_LO-1:CNT_LO] <= CNT_OUT_W'(WINDOW),
        "valid count above window depth")

    `ASSERT_RST(a_dist_range, aclk, aresetn,
        m_axis_tvalid |-> m_axis_tdata[DIST_W-1:0] <= DIST_W'(DIST_MAX),
        "distance above saturation value")

    // a clear request accepted with no result pending produces no result
    `ASSERT_RST(a_clear_silent, aclk, aresetn,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CLEAR && !m_axis_tvalid
            |=> ##1 !m_axis_tvalid,
        "clear request produced a result")

endmodule

bind ir_range_to_cm_with_gated_average_core irgavg_checker u_irgavg_checker (.*);

`default_nettype wire

>>> dv/tb_ir_range_to_cm_with_gated_average_core.sv
// ----------------------------------------------------------------------------
// tb_ir_range_to_cm_with_gated_average_core
// Drives raw range readings and clear commands into the core. Expected
// distance, gated average and valid count come from a local predictor that
// keeps its own conversion table, history and register copies. Every result
// is checked against the oldest pending request. Random gaps on the input,
// random stalls on the output and register settings change from phase to
// phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ir_range_to_cm_with_gated_average_core;
    import irgavg_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int AVG_LSB       = DIST_W;
    localparam int CNT_LSB       = DIST_W + AVG_W;

    typedef struct packed {
        logic [DIST_W-1:0]    dist_cm;
        logic [AVG_W-1:0]     avg_cm;
        logic [CNT_OUT_W-1:0] count;
    } range_result_t;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [9:0] adc_sample
    logic [CMD_W-1:0]     s_axis_tuser;   // [0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [13:0] distance_cm, [21:14] averaged_cm, [24:22] valid_count
    logic                 cfg_wr_en;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    // predictor state
    logic [DIST_W-1:0] cm_lut [ROM_DEPTH];
    logic [DIST_W-1:0] dist_history [WINDOW];
    logic [CFG_W-1:0]  valid_limit_q;
    logic [CFG_W-1:0]  fallback_q;
    range_result_t     pending_ranges[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          sender_gaps    = 1'b0;
    int          burst_left     = 0;
    ready_mode_t ready_mode     = READY_ALWAYS;
    logic [15:0] ready_pattern  = 16'hffff;
    int          hold_request   = 0;

    ir_range_to_cm_with_gated_average_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // unsigned q32 log2, fraction bits from repeated squaring of a q31 mantissa
    function automatic bit [63:0] q32_log2(input bit [31:0] v);
        bit [63:0] mant;
        bit [31:0] fbits;
        int        ip;
        if (v == 32'd0) begin
            return 64'd0;
        end
        ip = 31;
        while (!v[ip]) begin
            ip--;
        end
        mant  = 64'(v) << (31 - ip);
        fbits = '0;
        repeat (32) begin
            mant  = (mant * mant) >> 31;
            fbits = {fbits[30:0], 1'b0};
            if (mant[32]) begin
                mant     = mant >> 1;
                fbits[0] = 1'b1;
            end
        end
        return (64'(ip) << 32) | 64'(fbits);
    endfunction

    // largest d with log2(2d-1) <= exponent + 1, i.e. the power law rounded half up, less 10
    function automatic bit [DIST_W-1:0] cm_of(input int unsigned x, input longint base_exp);
        longint      thr;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (x == 0) begin
            return DIST_W'(DIST_MAX);
        end
        thr = base_exp - longint'((q32_log2(32'(x)) * 64'd935) / 64'd1000)
              + (longint'(1) << 32);
        lo  = 0;
        hi  = 16383;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (longint'(q32_log2(32'(2 * mid - 1))) <= thr) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (lo < 10) begin
            return '0;
        end
        lo = lo - 10;
        return (lo > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(lo);
    endfunction

    function automatic void build_cm_lut();
        longint base_exp;
        base_exp = longint'(q32_log2(32'd1065008)) - longint'(q32_log2(32'd100));
        for (int x = 0; x < ROM_DEPTH; x++) begin
            cm_lut[x] = cm_of(x, base_exp);
        end
    endfunction

    function automatic void predict_request(input logic [CMD_W-1:0] cmd,
                                            input logic [ADC_BITS-1:0] x);
        range_result_t r;
        int unsigned   sum;
        int unsigned   cnt;
        int unsigned   avg;
        if (cmd == CMD_CLEAR) begin
            foreach (dist_history[i]) begin
                dist_history[i] = CLEAR_VALUE;
            end
            return;
        end
        r.dist_cm = cm_lut[x];
        for (int i = WINDOW - 1; i > 0; i--) begin
            dist_history[i] = dist_history[i - 1];
        end
        dist_history[0] = r.dist_cm;
        sum = 0;
        cnt = 0;
        foreach (dist_history[i]) begin
            if (dist_history[i] > 0 && dist_history[i] < valid_limit_q) begin
                sum += dist_history[i];
                cnt++;
            end
        end
        r.avg_cm = fallback_q;
        if (cnt != 0) begin
            avg = sum / cnt;
            if (avg > 0 && avg < fallback_q) begin
                r.avg_cm = AVG_W'(avg);
            end
        end
        r.count = CNT_OUT_W'(cnt);
        pending_ranges.push_back(r);
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin : check_results
        range_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_ranges.size() == 0) begin
                $error("unexpected result, tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_ranges.pop_front();
                if (m_axis_tdata[DIST_W-1:0] !== want.dist_cm) begin
                    $error("distance_cm: expected %0d, got %0d",
                           want.dist_cm, m_axis_tdata[DIST_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[AVG_LSB +: AVG_W] !== want.avg_cm) begin
                    $error("averaged_cm: expected %0d, got %0d",
                           want.avg_cm, m_axis_tdata[AVG_LSB +: AVG_W]);
                    mismatch_count++;
                end
                if (m_axis_tdata[CNT_LSB +: CNT_OUT_W] !== want.count) begin
                    $error("valid_count: expected %0d, got %0d",
                           want.count, m_axis_tdata[CNT_LSB +: CNT_OUT_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial begin : drive_ready
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (ready_mode == READY_RANDOM && hold_left == 0 && $urandom_range(0, 60) == 0) begin
                hold_left = $urandom_range(5, 40);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS: begin
                        m_axis_tready <= 1'b1;
                    end
                    READY_RANDOM: begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_axis_tready <= ready_pattern[0];
                        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADC_BITS-1:0] x);
        int gap;
        gap = 0;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 24);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(x);
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        predict_request(cmd, x);
    endtask

    // stop offering, drain every result, then let a trailing clear finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_ranges.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] fallback);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_VALID_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        valid_limit_q = limit;
        cfg_addr  <= REG_FALLBACK;
        cfg_wdata <= fallback;
        @(posedge aclk);
        fallback_q = fallback;
        cfg_wr_en <= 1'b0;
    endtask

    // leans toward high raw readings so short distances fill the history
    function automatic logic [ADC_BITS-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return ADC_BITS'($urandom_range(350, 1023));
        end else if (sel < 70) begin
            return ADC_BITS'($urandom_range(0, 1023));
        end else if (sel < 90) begin
            return ADC_BITS'($urandom_range(40, 350));
        end
        return ADC_BITS'($urandom_range(0, 40));
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        sender_gaps = 1'b0;
        ready_mode  = READY_ALWAYS;
        send_request(CMD_SAMPLE, 10'd0);      // saturates to the maximum distance
        send_request(CMD_SAMPLE, 10'd1);
        send_request(CMD_SAMPLE, 10'd1023);
        send_request(CMD_SAMPLE, 10'd512);
        send_request(CMD_SAMPLE, 10'h2aa);
        send_request(CMD_SAMPLE, 10'h155);
        send_request(CMD_SAMPLE, 10'd700);
        send_request(CMD_SAMPLE, 10'd900);
        send_request(CMD_SAMPLE, 10'd1000);
        send_request(CMD_SAMPLE, 10'd600);
        send_request(CMD_SAMPLE, 10'd800);   // whole window valid
        send_request(CMD_CLEAR, 10'h3ff);
        send_request(CMD_SAMPLE, 10'd450);
        send_request(CMD_CLEAR, 10'd0);
        send_request(CMD_CLEAR, 10'h155);    // back-to-back clears
        send_request(CMD_SAMPLE, 10'd2);
        send_request(CMD_SAMPLE, 10'd52);
        send_request(CMD_SAMPLE, 10'd300);
        send_request(CMD_SAMPLE, 10'd1022);
        send_request(CMD_SAMPLE, 10'd0);
    endtask

    task automatic test_register_extremes();
        logic [CFG_W-1:0] limits [6] = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd1, VALID_LIMIT_RST};
        logic [CFG_W-1:0] fbacks [6] = '{FALLBACK_RST, 8'd255, 8'd0, 8'd0, 8'd255, FALLBACK_RST};
        sender_gaps = 1'b1;
        ready_mode  = READY_RANDOM;
        foreach (limits[k]) begin
            wait_idle();
            set_config(limits[k], fbacks[k]);
            repeat (12) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(CMD_CLEAR, ADC_BITS'($urandom_range(0, 1023)));
                end else begin
                    send_request(CMD_SAMPLE, pick_sample());
                end
            end
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        sender_gaps  = 1'b0;
        ready_mode   = READY_ALWAYS;
        hold_request = 300;
        repeat (20) begin
            send_request(CMD_SAMPLE, pick_sample());
        end
        wait_idle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            set_config(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
            if (phase == 0) begin
                sender_gaps = 1'b0;
                ready_mode  = READY_ALWAYS;
            end else begin
                sender_gaps   = ($urandom_range(0, 3) != 0);
                ready_mode    = ready_mode_t'($urandom_range(0, 2));
                ready_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
            end
            repeat (165) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_request(CMD_CLEAR, ADC_BITS'($urandom_range(0, 1023)));
                end else begin
                    send_request(CMD_SAMPLE, pick_sample());
                end
            end
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_SAMPLE;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= REG_VALID_LIMIT;
        cfg_wdata     <= '0;
        valid_limit_q = VALID_LIMIT_RST;
        fallback_q    = FALLBACK_RST;
        foreach (dist_history[i]) begin
            dist_history[i] = CLEAR_VALUE;
        end
        build_cm_lut();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/irgavg_pkg.sv
sv/irgavg_ram.sv
sv/irgavg_rom.sv
sv/irgavg_div.sv
sv/ir_range_to_cm_with_gated_average_core.sv
sv/irgavg_checker.sv
dv/tb_ir_range_to_cm_with_gated_average_core.sv
